[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define SFE_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition implies a property in the cycle after it
`define SFE_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[rtl/sfe_pkg.sv]
// ----------------------------------------------------------------------------
// sfe_pkg
// shared widths, register codes and bus types of the stereo echo block
// ----------------------------------------------------------------------------
`default_nettype none

package sfe_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int POS_W      = 16;
	localparam int CHAN_W     = 1;
	localparam int MEM_AW     = CHAN_W + POS_W;
	localparam int DELAY_W    = 16;
	localparam int GAIN_W     = 17;
	localparam int FRAC_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FB    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WET   = 2'd2;

	localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd24000;
	localparam logic [GAIN_W-1:0]  FB_LIMIT    = 17'd58982;
	localparam logic [GAIN_W-1:0]  WET_LIMIT   = 17'd65536;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic [MEM_AW-1:0] rd_addr;
		logic              written;
	} sfe_rd_t;

	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		sample_t           data;
	} sfe_wr_t;

endpackage

`default_nettype wire

[rtl/sfe_addr.sv]
// ----------------------------------------------------------------------------
// sfe_addr
// per-channel write pointers and fill tracking, read address generation
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_addr (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            accept,
	input  wire logic [sfe_pkg::CHAN_W-1:0]      chan,
	input  wire logic [sfe_pkg::DELAY_W-1:0]     delay,
	output sfe_pkg::sfe_rd_t                     rd,
	output logic      [sfe_pkg::POS_W-1:0]       wr_pos
);

	localparam int NCH = 2 ** sfe_pkg::CHAN_W;

	logic [sfe_pkg::POS_W-1:0] wp_q [NCH];
	logic [NCH-1:0]            wrapped_q;
	logic [sfe_pkg::POS_W-1:0] delay_eff;
	logic [sfe_pkg::POS_W-1:0] rd_pos;

	always_comb begin
		wr_pos     = wp_q[chan];
		delay_eff  = (delay == '0) ? sfe_pkg::POS_W'(1) : sfe_pkg::POS_W'(delay);
		rd_pos     = wr_pos - delay_eff;
		rd.rd_addr = {chan, rd_pos};
		// entry holds real data once written since reset
		rd.written = wrapped_q[chan] | (rd_pos < wr_pos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				wp_q[i] <= '0;
			end
			wrapped_q <= '0;
		end else if (accept) begin
			wp_q[chan] <= wr_pos + 1'b1;
			if (&wr_pos) begin
				wrapped_q[chan] <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/sfe_store.sv]
// ----------------------------------------------------------------------------
// sfe_store
// echo sample memory, one read and one write port, with write forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_store (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        rd_en,
	input  wire sfe_pkg::sfe_rd_t            rd,
	input  wire sfe_pkg::sfe_rd_t            rd_s1,
	input  wire sfe_pkg::sfe_wr_t            wr,
	output sfe_pkg::sample_t                 delayed
);

	localparam int DEPTH = 2 ** sfe_pkg::MEM_AW;

	sfe_pkg::sample_t            mem [DEPTH];
	sfe_pkg::sample_t            rdata_s1;
	logic                        fwd_vld_q;
	logic [sfe_pkg::MEM_AW-1:0]  fwd_addr_q;
	sfe_pkg::sample_t            fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd.rd_addr];
		end
	end

	// last write, covers a read issued at the edge of that write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (wr.en) begin
			fwd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			fwd_addr_q <= wr.addr;
			fwd_data_q <= wr.data;
		end
	end

	always_comb begin
		if (fwd_vld_q && (fwd_addr_q == rd_s1.rd_addr)) begin
			delayed = fwd_data_q;
		end else if (rd_s1.written) begin
			delayed = rdata_s1;
		end else begin
			delayed = '0;
		end
	end

endmodule

`default_nettype wire

[rtl/sfe_mix.sv]
// ----------------------------------------------------------------------------
// sfe_mix
// gain multiply stage, then q16 rounding, dry add and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_mix (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire sfe_pkg::sample_t              delayed,
	input  wire sfe_pkg::sample_t              x,
	input  wire logic [sfe_pkg::GAIN_W-1:0]    fb_gain,
	input  wire logic [sfe_pkg::GAIN_W-1:0]    wet_gain,
	output sfe_pkg::sample_t                   fb_sum,
	output sfe_pkg::sample_t                   out_sum
);

	localparam int PROD_W = sfe_pkg::SAMPLE_W + sfe_pkg::GAIN_W + 1;
	localparam int SUM_W  = PROD_W - sfe_pkg::FRAC_W + 1;
	localparam logic signed [PROD_W-1:0] ROUND_HALF =
		PROD_W'(1 << (sfe_pkg::FRAC_W - 1));
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (sfe_pkg::SAMPLE_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(1 << (sfe_pkg::SAMPLE_W - 1)));

	logic signed [PROD_W-1:0] fb_prod_s2;
	logic signed [PROD_W-1:0] wet_prod_s2;
	sfe_pkg::sample_t         x_s2;

	function automatic sfe_pkg::sample_t mix_sat(input logic signed [PROD_W-1:0] p,
		input sfe_pkg::sample_t dry);
		logic signed [PROD_W-1:0] r;
		logic signed [SUM_W-1:0]  s;
		r = p + ROUND_HALF;
		s = SUM_W'(r >>> sfe_pkg::FRAC_W) + SUM_W'(dry);
		if (s > SAT_HI) begin
			return sfe_pkg::SAMPLE_W'(SAT_HI);
		end else if (s < SAT_LO) begin
			return sfe_pkg::SAMPLE_W'(SAT_LO);
		end
		return sfe_pkg::SAMPLE_W'(s);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			fb_prod_s2  <= PROD_W'(delayed) * PROD_W'($signed({1'b0, fb_gain}));
			wet_prod_s2 <= PROD_W'(delayed) * PROD_W'($signed({1'b0, wet_gain}));
			x_s2        <= x;
		end
	end

	always_comb begin
		fb_sum  = mix_sat(fb_prod_s2, x_s2);
		out_sum = mix_sat(wet_prod_s2, x_s2);
	end

endmodule

`default_nettype wire

[rtl/stereo_feedback_echo_delay_top.sv]
// ----------------------------------------------------------------------------
// stereo_feedback_echo_delay_top
// stereo feedback echo, one circular region per channel in a shared sample store
//
//   channel  | signals                               | direction
//   ---------+---------------------------------------+----------
//   input    | in_valid in_ready chan in_sample      | in
//   output   | out_valid out_ready out_chan out_sample | out
//   config   | cfg_valid cfg_ready cfg_index cfg_data | in
//
// one request per cycle while in_ready is high; a request moves through s1
// and s2 to the output register; in_ready drops while a request reads
// the entry that the request just ahead of it on the same channel, now in
// s1, writes (delay of one); a stalled output holds the whole pipeline
// reset is asynchronous; the store is not cleared, per-channel fill
// tracking makes never-written entries read as silence
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stereo_feedback_echo_delay_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [sfe_pkg::CHAN_W-1:0]           chan,
	input  wire logic signed [sfe_pkg::SAMPLE_W-1:0]  in_sample,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [sfe_pkg::CHAN_W-1:0]                out_chan,
	output logic signed [sfe_pkg::SAMPLE_W-1:0]       out_sample,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [sfe_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [sfe_pkg::CFG_DATA_W-1:0]       cfg_data
);

	logic [sfe_pkg::DELAY_W-1:0]  delay_q;
	logic [sfe_pkg::GAIN_W-1:0]   fb_q;
	logic [sfe_pkg::GAIN_W-1:0]   wet_q;

	logic                         adv;
	logic                         hazard;
	logic                         accept;
	sfe_pkg::sfe_rd_t             rd;
	logic [sfe_pkg::POS_W-1:0]    wr_pos;

	logic                         vld_s1;
	logic [sfe_pkg::CHAN_W-1:0]   chan_s1;
	sfe_pkg::sample_t             x_s1;
	logic [sfe_pkg::POS_W-1:0]    wp_s1;
	sfe_pkg::sfe_rd_t             rd_s1;

	logic                         vld_s2;
	logic [sfe_pkg::CHAN_W-1:0]   chan_s2;
	logic [sfe_pkg::POS_W-1:0]    wp_s2;

	logic                         out_vld_q;
	logic [sfe_pkg::CHAN_W-1:0]   out_chan_q;
	sfe_pkg::sample_t             out_sample_q;

	sfe_pkg::sample_t             delayed;
	sfe_pkg::sample_t             fb_sum;
	sfe_pkg::sample_t             out_sum;
	sfe_pkg::sfe_wr_t             wr;

	// configuration, gains clamped on write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= sfe_pkg::DELAY_RESET;
			fb_q    <= '0;
			wet_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sfe_pkg::REG_DELAY: begin
					delay_q <= cfg_data[sfe_pkg::DELAY_W-1:0];
				end
				sfe_pkg::REG_FB: begin
					if ({1'b0, cfg_data[15:0]} > sfe_pkg::FB_LIMIT) begin
						fb_q <= sfe_pkg::FB_LIMIT;
					end else begin
						fb_q <= {1'b0, cfg_data[15:0]};
					end
				end
				sfe_pkg::REG_WET: begin
					if (cfg_data > sfe_pkg::WET_LIMIT) begin
						wet_q <= sfe_pkg::WET_LIMIT;
					end else begin
						wet_q <= cfg_data;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// pipeline control
	assign adv      = !out_vld_q || out_ready;
	assign hazard   = vld_s1 && (rd.rd_addr == {chan_s1, wp_s1});
	assign in_ready = adv && !hazard;
	assign accept   = in_valid && in_ready;

	sfe_addr u_addr (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.chan   (chan),
		.delay  (delay_q),
		.rd     (rd),
		.wr_pos (wr_pos)
	);

	sfe_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd      (rd),
		.rd_s1   (rd_s1),
		.wr      (wr),
		.delayed (delayed)
	);

	sfe_mix u_mix (
		.clk      (clk),
		.en       (adv),
		.delayed  (delayed),
		.x        (x_s1),
		.fb_gain  (fb_q),
		.wet_gain (wet_q),
		.fb_sum   (fb_sum),
		.out_sum  (out_sum)
	);

	always_comb begin
		wr.en   = adv && vld_s2;
		wr.addr = {chan_s2, wp_s2};
		wr.data = fb_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= accept;
			vld_s2    <= vld_s1;
			out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chan_s1 <= chan;
			x_s1    <= in_sample;
			wp_s1   <= wr_pos;
			rd_s1   <= rd;
		end
		if (adv && vld_s1) begin
			chan_s2 <= chan_s1;
			wp_s2   <= wp_s1;
		end
		if (adv && vld_s2) begin
			out_chan_q   <= chan_s2;
			out_sample_q <= out_sum;
		end
	end

	assign out_valid  = out_vld_q;
	assign out_chan   = out_chan_q;
	assign out_sample = out_sample_q;

	`SFE_ASSERT(a_no_ahead_clash, (vld_s1 && vld_s2) |-> (rd_s1.rd_addr != {chan_s2, wp_s2}), "read overlaps pending write")
	`SFE_ASSERT_NEXT(a_stall_holds, !adv, (vld_s1 == $past(vld_s1)) && (vld_s2 == $past(vld_s2)), "pipeline moved during stall")
	`SFE_ASSERT_NEXT(a_write_gives_out, wr.en, out_vld_q && (out_chan == $past(chan_s2)), "write without matching result")

endmodule

`default_nettype wire

[dv/stereo_feedback_echo_delay_top_tb.sv]
// ----------------------------------------------------------------------------
// stereo_feedback_echo_delay_top_tb
// self-checking bench for the stereo feedback echo: a queue-fed driver
// offers audio requests with random gaps, a monitor predicts each result
// from its own copy of the per-channel echo stores and compares every
// output in order, while the receiver stalls at random; register
// settings change between phases once the block has drained
// ----------------------------------------------------------------------------
module stereo_feedback_echo_delay_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [sfe_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int unsigned STORE_DEPTH = 1 << sfe_pkg::POS_W;
	localparam int NUM_CHAN = 1 << sfe_pkg::CHAN_W;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASE_ITEMS = 100;
	localparam int LONG_ITEMS = 40;
	localparam longint SMP_HI = (longint'(1) << (sfe_pkg::SAMPLE_W - 1)) - 1;
	localparam longint SMP_LO = -SMP_HI - 1;
	localparam sfe_pkg::sample_t S_MAX = sfe_pkg::sample_t'(SMP_HI);
	localparam sfe_pkg::sample_t S_MIN = sfe_pkg::sample_t'(SMP_LO);

	typedef struct packed {
		logic [sfe_pkg::CHAN_W-1:0] ch;
		sfe_pkg::sample_t           smp;
	} audio_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [sfe_pkg::CHAN_W-1:0]     chan = '0;
	sfe_pkg::sample_t               in_sample = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [sfe_pkg::CHAN_W-1:0]     out_chan;
	sfe_pkg::sample_t               out_sample;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [sfe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [sfe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	audio_t send_q[$];
	audio_t echo_q[$];

	sfe_pkg::sample_t            tap_store [NUM_CHAN][STORE_DEPTH];
	logic [sfe_pkg::POS_W-1:0]   wr_pos [NUM_CHAN];
	logic [sfe_pkg::DELAY_W-1:0] delay_reg;
	logic [sfe_pkg::FRAC_W-1:0]  fb_reg;
	logic [sfe_pkg::GAIN_W-1:0]  wet_reg;

	bit in_taken;
	bit quiet;
	bit hold_req;
	int in_gap;
	int rdy_stall;
	int hold_left;
	int err_count;

	stereo_feedback_echo_delay_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.chan       (chan),
		.in_sample  (in_sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_chan   (out_chan),
		.out_sample (out_sample),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		err_count++;
	endtask

	function automatic int pick_gap();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 60)
			return 0;
		if (r < 92)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(10, 40));
	endfunction

	// round half up while dropping the fraction bits
	function automatic longint q16_round(input longint p);
		return (p + 64'sd32768) >>> sfe_pkg::FRAC_W;
	endfunction

	function automatic sfe_pkg::sample_t clip_sample(input longint v);
		if (v > SMP_HI)
			return S_MAX;
		if (v < SMP_LO)
			return S_MIN;
		return sfe_pkg::sample_t'(v);
	endfunction

	function automatic sfe_pkg::sample_t rand_sample();
		int r;
		r = int'($urandom_range(0, 9));
		case (r)
			0: return S_MAX;
			1: return S_MIN;
			2, 3: return sfe_pkg::sample_t'(int'($urandom_range(0, 511)) - 256);
			default: return sfe_pkg::sample_t'($urandom);
		endcase
	endfunction

	// one echo step: read the delayed tap, write back the feedback sum
	function automatic audio_t echo_predict(input audio_t req);
		logic [sfe_pkg::DELAY_W-1:0] dly;
		logic [sfe_pkg::GAIN_W-1:0]  fbg;
		logic [sfe_pkg::GAIN_W-1:0]  wetg;
		logic [sfe_pkg::POS_W-1:0]   wp;
		logic [sfe_pkg::POS_W-1:0]   rp;
		sfe_pkg::sample_t            x;
		sfe_pkg::sample_t            tap;
		sfe_pkg::sample_t            fb_sum;
		audio_t                      res;
		dly = (delay_reg == '0) ? sfe_pkg::DELAY_W'(1) : delay_reg;
		fbg = ({1'b0, fb_reg} > sfe_pkg::FB_LIMIT) ? sfe_pkg::FB_LIMIT : {1'b0, fb_reg};
		wetg = (wet_reg > sfe_pkg::WET_LIMIT) ? sfe_pkg::WET_LIMIT : wet_reg;
		x = req.smp;
		wp = wr_pos[req.ch];
		rp = wp - sfe_pkg::POS_W'(dly);
		tap = tap_store[req.ch][rp];
		fb_sum = clip_sample(longint'(x) + q16_round(longint'(tap) * longint'(fbg)));
		res.ch = req.ch;
		res.smp = clip_sample(longint'(x) + q16_round(longint'(tap) * longint'(wetg)));
		tap_store[req.ch][wp] = fb_sum;
		wr_pos[req.ch] = wp + 1'b1;
		return res;
	endfunction

	task automatic push_item(input logic [sfe_pkg::CHAN_W-1:0] ch,
			input sfe_pkg::sample_t smp);
		send_q.push_back('{ch: ch, smp: smp});
	endtask

	task automatic write_reg(input logic [sfe_pkg::CFG_IDX_W-1:0] idx,
			input logic [sfe_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drain();
		while (send_q.size() != 0 || in_valid || echo_q.size() != 0)
			@(posedge clk);
	endtask

	// driver
	always @(negedge clk) begin
		audio_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (in_taken) begin
				in_taken = 1'b0;
				in_gap = quiet ? 0 : pick_gap();
			end
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (send_q.size() != 0) begin
				nxt = send_q.pop_front();
				in_valid <= 1'b1;
				chan <= nxt.ch;
				in_sample <= nxt.smp;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		logic rdy;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				rdy = 1'b0;
			end else if (quiet) begin
				rdy = 1'b1;
			end else if (rdy_stall > 0) begin
				rdy_stall--;
				rdy = 1'b0;
			end else begin
				rdy_stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
				rdy = (rdy_stall == 0);
			end
			out_ready <= rdy;
		end
	end

	// monitor
	always @(posedge clk) begin
		audio_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sfe_pkg::REG_DELAY: delay_reg = cfg_data[sfe_pkg::DELAY_W-1:0];
					sfe_pkg::REG_FB:    fb_reg = cfg_data[sfe_pkg::FRAC_W-1:0];
					sfe_pkg::REG_WET:   wet_reg = cfg_data[sfe_pkg::GAIN_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				in_taken = 1'b1;
				echo_q.push_back(echo_predict('{ch: chan, smp: in_sample}));
			end
			if (out_valid && out_ready) begin
				if (echo_q.size() == 0) begin
					report_mismatch($sformatf("unexpected output chan %0d sample %0d",
						out_chan, out_sample));
				end else begin
					want = echo_q.pop_front();
					if (out_chan !== want.ch)
						report_mismatch($sformatf("out_chan %0d, want %0d",
							out_chan, want.ch));
					if (out_sample !== want.smp)
						report_mismatch($sformatf("out_sample %0d, want %0d",
							out_sample, want.smp));
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [sfe_pkg::DELAY_W-1:0] dly;
		logic [sfe_pkg::FRAC_W-1:0]  fbv;
		logic [sfe_pkg::GAIN_W-1:0]  wetv;
		int                          spin;
		for (int c = 0; c < NUM_CHAN; c++) begin
			wr_pos[c] = '0;
			for (int unsigned a = 0; a < STORE_DEPTH; a++)
				tap_store[c][a] = '0;
		end
		delay_reg = sfe_pkg::DELAY_RESET;
		fb_reg = '0;
		wet_reg = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: long delay, no echo
		push_item(1'b0, S_MAX);
		push_item(1'b1, S_MIN);
		push_item(1'b0, '0);
		push_item(1'b1, '1);
		wait_drain();

		// zero delay acts as one, gains over their limits, spare index ignored
		write_reg(sfe_pkg::REG_DELAY, 17'h10000);
		write_reg(sfe_pkg::REG_FB, 17'h1FFFF);
		write_reg(sfe_pkg::REG_WET, 17'h1FFFF);
		write_reg(REG_SPARE, 17'h1FFFF);
		repeat (3) push_item(1'b0, S_MAX);
		repeat (3) push_item(1'b0, S_MIN);
		push_item(1'b1, S_MAX);
		push_item(1'b1, S_MAX);
		push_item(1'b0, sfe_pkg::sample_t'(1));
		push_item(1'b1, '1);
		push_item(1'b0, S_MIN + sfe_pkg::sample_t'(1));
		push_item(1'b1, sfe_pkg::sample_t'(24'h555555));
		push_item(1'b1, sfe_pkg::sample_t'(24'hAAAAAA));
		wait_drain();

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: dly = 16'd1;
				1: dly = 16'd2;
				2: dly = sfe_pkg::DELAY_W'($urandom_range(3, 16));
				3: dly = sfe_pkg::DELAY_W'($urandom_range(1, 8));
				4: dly = 16'hFFFF;
				5: dly = sfe_pkg::DELAY_W'($urandom_range(1, 64));
				6: dly = sfe_pkg::DELAY_W'($urandom_range(1, 300));
				7: dly = sfe_pkg::DELAY_W'($urandom_range(1, 4));
				default: dly = '0;
			endcase
			fbv = (ph == 0) ? '0 :
				(ph == 1) ? sfe_pkg::FB_LIMIT[sfe_pkg::FRAC_W-1:0] :
				sfe_pkg::FRAC_W'($urandom_range(0, 65535));
			wetv = (ph == 0) ? '0 : (ph == 1) ? sfe_pkg::WET_LIMIT :
				sfe_pkg::GAIN_W'($urandom_range(0, 131071));
			write_reg(sfe_pkg::REG_DELAY, {1'($urandom_range(0, 1)), dly});
			write_reg(sfe_pkg::REG_FB, {1'($urandom_range(0, 1)), fbv});
			write_reg(sfe_pkg::REG_WET, wetv);
			if ($urandom_range(0, 1))
				write_reg(REG_SPARE, sfe_pkg::CFG_DATA_W'($urandom));
			quiet = (ph == 3);
			for (int i = 0; i < PHASE_ITEMS; i++)
				push_item(sfe_pkg::CHAN_W'($urandom_range(0, 1)), rand_sample());
			// long output stall while requests keep coming
			if (ph == 5)
				hold_req = 1'b1;
			wait_drain();
		end

		// longest delay, reads fall in the never-written part of the store
		write_reg(sfe_pkg::REG_DELAY, 17'h0FFFF);
		write_reg(sfe_pkg::REG_FB, 17'd45000);
		write_reg(sfe_pkg::REG_WET, sfe_pkg::WET_LIMIT);
		quiet = 1'b1;
		for (int i = 0; i < LONG_ITEMS; i++)
			push_item(1'b0, rand_sample());
		for (int i = 0; i < 20; i++)
			push_item(1'b1, rand_sample());

		while (send_q.size() != 0 || in_valid)
			@(posedge clk);
		spin = 0;
		while (echo_q.size() != 0 && spin < 10000) begin
			@(posedge clk);
			spin++;
		end
		repeat (8) @(posedge clk);
		if (echo_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", echo_q.size()));

		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[stereo_feedback_echo_delay_top.f]
+incdir+rtl
rtl/sfe_pkg.sv
rtl/sfe_addr.sv
rtl/sfe_store.sv
rtl/sfe_mix.sv
rtl/stereo_feedback_echo_delay_top.sv
dv/stereo_feedback_echo_delay_top_tb.sv
